// ----- src/pcg_pkg.sv -----
package pcg_pkg;

  localparam int StateW = 64;
  localparam int WordW  = 32;
  localparam int SeqW   = 63;
  localparam int DivCntW = $clog2(WordW);

  localparam logic [StateW-1:0] LcgMult    = 64'd6364136223846793005;
  localparam logic [StateW-1:0] ResetState = 64'h853c49e6748fea9b;
  localparam logic [StateW-1:0] ResetInc   = 64'hda3e39cb94b95bdb;

  // tuser codes on the input side
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  // config register indexes
  localparam logic REG_SEED_STATE    = 1'b0;
  localparam logic REG_SEED_SEQUENCE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED0,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_ADD_SEED,
    S_THR_LOAD,
    S_THR_DIV,
    S_THR_SAVE,
    S_MOD_LOAD,
    S_MOD_DIV,
    S_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    K_RESEED1,
    K_RESEED2,
    K_RAW,
    K_BOUNDED
  } item_kind_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_ACCEPT,
    DP_SEED_INIT,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_MUL3,
    DP_ADD_SEED,
    DP_DIV_LOAD_THR,
    DP_DIV_LOAD_R,
    DP_DIV_STEP,
    DP_THR_SAVE
  } dp_op_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RAW,
    RES_REM
  } res_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     out_load;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic in_bound_zero;  // bound on the input port is zero
    logic r_ok;           // captured output passes the rejection test
  } dp_status_t;

endpackage

// ----- src/pcg_datapath.sv -----
module pcg_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [pcg_pkg::StateW-1:0]     cfg_data,
  input  logic [pcg_pkg::WordW-1:0]      in_bound,
  input  pcg_pkg::dp_cmd_t               cmd,
  output pcg_pkg::dp_status_t            status,
  output logic [pcg_pkg::WordW-1:0]      result
);

  localparam int W = pcg_pkg::WordW;
  localparam int S = pcg_pkg::StateW;

  logic [S-1:0]                seed_state;
  logic [pcg_pkg::SeqW-1:0]    seed_seq;
  logic [S-1:0]                gen_state;
  logic [S-1:0]                inc;
  logic [W-1:0]                bound;
  logic [W-1:0]                r_reg;
  logic [W-1:0]                thr;
  logic [2*W-1:0]              prod;
  logic [W-1:0]                hi_acc;
  logic [W-1:0]                dq;
  logic [W-1:0]                rem;

  logic [W-1:0]                mixed;
  logic [4:0]                  rot;
  logic [2*W-1:0]              rot_dbl;
  logic [W-1:0]                r_now;
  logic [W-1:0]                mul_a;
  logic [W-1:0]                mul_b;
  logic [2*W-1:0]              mul_p;
  logic [W:0]                  rem_sh;
  logic [W:0]                  rem_diff;

  // XSH-RR output of the current state
  always_comb begin
    mixed   = W'(((gen_state >> 18) ^ gen_state) >> 27);
    rot     = gen_state[S-1:S-5];
    rot_dbl = {mixed, mixed} >> rot;
    r_now   = rot_dbl[W-1:0];
  end

  // one shared 32x32 multiplier, operands picked by step
  always_comb begin
    case (cmd.op)
      pcg_pkg::DP_MUL1: begin
        mul_a = gen_state[S-1:W];
        mul_b = pcg_pkg::LcgMult[W-1:0];
      end
      pcg_pkg::DP_MUL2: begin
        mul_a = gen_state[W-1:0];
        mul_b = pcg_pkg::LcgMult[S-1:W];
      end
      default: begin
        mul_a = gen_state[W-1:0];
        mul_b = pcg_pkg::LcgMult[W-1:0];
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // restoring divide, remainder only
  always_comb begin
    rem_sh   = {rem, dq[W-1]};
    rem_diff = rem_sh - {1'b0, bound};
  end

  assign status.in_bound_zero = (in_bound == '0);
  assign status.r_ok          = (r_reg >= thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_state <= '0;
      seed_seq   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pcg_pkg::REG_SEED_STATE:    seed_state <= cfg_data;
        pcg_pkg::REG_SEED_SEQUENCE: seed_seq   <= cfg_data[pcg_pkg::SeqW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= pcg_pkg::ResetState;
      inc       <= pcg_pkg::ResetInc;
    end else begin
      case (cmd.op)
        pcg_pkg::DP_SEED_INIT: begin
          gen_state <= '0;
          inc       <= {seed_seq, 1'b1};
        end
        pcg_pkg::DP_MUL3:     gen_state <= {hi_acc, prod[W-1:0]} + inc;
        pcg_pkg::DP_ADD_SEED: gen_state <= gen_state + seed_state;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      pcg_pkg::DP_ACCEPT: bound <= in_bound;
      pcg_pkg::DP_MUL0: begin
        r_reg <= r_now;
        prod  <= mul_p;
      end
      pcg_pkg::DP_MUL1: hi_acc <= prod[2*W-1:W] + mul_p[W-1:0];
      pcg_pkg::DP_MUL2: hi_acc <= hi_acc + mul_p[W-1:0];
      pcg_pkg::DP_DIV_LOAD_THR: begin
        dq  <= W'(0) - bound;
        rem <= '0;
      end
      pcg_pkg::DP_DIV_LOAD_R: begin
        dq  <= r_reg;
        rem <= '0;
      end
      pcg_pkg::DP_DIV_STEP: begin
        dq  <= {dq[W-2:0], 1'b0};
        rem <= rem_diff[W] ? rem_sh[W-1:0] : rem_diff[W-1:0];
      end
      pcg_pkg::DP_THR_SAVE: thr <= rem;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res_sel)
        pcg_pkg::RES_RAW: result <= r_reg;
        pcg_pkg::RES_REM: result <= rem;
        default:          result <= '0;
      endcase
    end
  end

endmodule

// ----- src/pcg_controller.sv -----
module pcg_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tuser,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  pcg_pkg::dp_status_t  status,
  output pcg_pkg::dp_cmd_t     cmd
);

  pcg_pkg::ctl_state_t              state, state_next;
  pcg_pkg::item_kind_t              kind, kind_next;
  logic [pcg_pkg::DivCntW-1:0]      cnt, cnt_next;
  logic                             out_free;

  assign s_tready = (state == pcg_pkg::S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcg_pkg::S_IDLE;
      kind  <= pcg_pkg::K_RAW;
      cnt   <= '0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next   = state;
    kind_next    = kind;
    cnt_next     = cnt;
    cmd.op       = pcg_pkg::DP_IDLE;
    cmd.out_load = 1'b0;
    cmd.res_sel  = pcg_pkg::RES_ZERO;
    case (state)
      pcg_pkg::S_IDLE: begin
        if (s_tvalid) begin
          cmd.op = pcg_pkg::DP_ACCEPT;
          if (s_tuser == pcg_pkg::OP_RESEED) begin
            kind_next  = pcg_pkg::K_RESEED1;
            state_next = pcg_pkg::S_SEED0;
          end else if (status.in_bound_zero) begin
            kind_next  = pcg_pkg::K_RAW;
            state_next = pcg_pkg::S_M0;
          end else begin
            kind_next  = pcg_pkg::K_BOUNDED;
            state_next = pcg_pkg::S_THR_LOAD;
          end
        end
      end
      pcg_pkg::S_SEED0: begin
        cmd.op     = pcg_pkg::DP_SEED_INIT;
        state_next = pcg_pkg::S_M0;
      end
      pcg_pkg::S_M0: begin
        cmd.op     = pcg_pkg::DP_MUL0;
        state_next = pcg_pkg::S_M1;
      end
      pcg_pkg::S_M1: begin
        cmd.op     = pcg_pkg::DP_MUL1;
        state_next = pcg_pkg::S_M2;
      end
      pcg_pkg::S_M2: begin
        cmd.op     = pcg_pkg::DP_MUL2;
        state_next = pcg_pkg::S_M3;
      end
      pcg_pkg::S_M3: begin
        cmd.op = pcg_pkg::DP_MUL3;
        case (kind)
          pcg_pkg::K_RESEED1: state_next = pcg_pkg::S_ADD_SEED;
          pcg_pkg::K_BOUNDED: state_next = status.r_ok ? pcg_pkg::S_MOD_LOAD : pcg_pkg::S_M0;
          default:            state_next = pcg_pkg::S_DONE;
        endcase
      end
      pcg_pkg::S_ADD_SEED: begin
        cmd.op     = pcg_pkg::DP_ADD_SEED;
        kind_next  = pcg_pkg::K_RESEED2;
        state_next = pcg_pkg::S_M0;
      end
      pcg_pkg::S_THR_LOAD: begin
        cmd.op     = pcg_pkg::DP_DIV_LOAD_THR;
        cnt_next   = '0;
        state_next = pcg_pkg::S_THR_DIV;
      end
      pcg_pkg::S_THR_DIV: begin
        cmd.op   = pcg_pkg::DP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == '1) begin
          state_next = pcg_pkg::S_THR_SAVE;
        end
      end
      pcg_pkg::S_THR_SAVE: begin
        cmd.op     = pcg_pkg::DP_THR_SAVE;
        state_next = pcg_pkg::S_M0;
      end
      pcg_pkg::S_MOD_LOAD: begin
        cmd.op     = pcg_pkg::DP_DIV_LOAD_R;
        cnt_next   = '0;
        state_next = pcg_pkg::S_MOD_DIV;
      end
      pcg_pkg::S_MOD_DIV: begin
        cmd.op   = pcg_pkg::DP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == '1) begin
          state_next = pcg_pkg::S_DONE;
        end
      end
      pcg_pkg::S_DONE: begin
        case (kind)
          pcg_pkg::K_RAW:     cmd.res_sel = pcg_pkg::RES_RAW;
          pcg_pkg::K_BOUNDED: cmd.res_sel = pcg_pkg::RES_REM;
          default:            cmd.res_sel = pcg_pkg::RES_ZERO;
        endcase
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = pcg_pkg::S_IDLE;
        end
      end
      default: state_next = pcg_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- src/permuted_congruential_generator_top.sv -----
// From s_tvalid&s_tready to m_tvalid: a zero-bound draw runs one state advance, a reseed two,
//   a bounded draw two 32-step divider passes plus one advance per output, rejected ones included.
// Throughput: one item at a time; the next item is taken once the result is written to the output
//   register, even while that result still waits for m_tready.
//   Each state advance runs steps M0 to M3 on one shared 32x32 multiplier.
// Reset (rst, synchronous): state and increment to the PCG32 initializer, seeds to zero.
module permuted_congruential_generator_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] bound
  input  logic        s_tuser,   // [0] operation (0 draw, 1 reseed)
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] random_value
  // configuration: index 0 seed_state, index 1 seed_sequence
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  pcg_pkg::dp_cmd_t    cmd;
  pcg_pkg::dp_status_t status;

  // Controller sequences: accept -> (threshold divide, or seed init, advance and seed add) ->
  // advance steps with rejection loop -> (modulo divide) -> output register load.
  pcg_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: LCG state, shared multiplier, XSH-RR output, restoring divider,
  // seed registers and the output data register.
  pcg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_bound  (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .result    (m_tdata)
  );

endmodule

// ----- src/pcg_checker.sv -----
module pcg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");

  // one item in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  // a new result only appears after the block was busy
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without work");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && s_tready)
    else $error("bad state after reset");

endmodule

bind permuted_congruential_generator_top pcg_checker u_pcg_checker (.*);

// ----- tb/sv/permuted_congruential_generator_top_test.sv -----
`timescale 1ns / 100ps

module permuted_congruential_generator_top_test;

  localparam int unsigned RowCount    = 12;     // rows in the directed table
  localparam int unsigned PhaseCount  = 6;      // random phases, each with its own seeds
  localparam int unsigned PhaseItems  = 271;    // items per random phase
  localparam int unsigned HoldCycles  = 400;    // long output hold-off, fills the block
  localparam int unsigned DrainCycles = 120;    // tail wait, above the bounded-draw latency
  localparam int unsigned QuietLimit  = 20000;  // cycles with no accepted item before giving up

  // one row of the directed table; known marks a result readable without the predictor
  typedef struct packed {
    logic        op;
    logic [31:0] bound;
    logic        known;
    logic [31:0] known_value;
  } draw_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] bound
  logic        s_tuser;   // [0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // [31:0] random_value
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;

  // predictor copy of the generator and its seed registers
  logic [pcg_pkg::StateW-1:0] gen_state;
  logic [pcg_pkg::StateW-1:0] gen_inc;
  logic [pcg_pkg::StateW-1:0] seed_st;
  logic [pcg_pkg::SeqW-1:0]   seed_seq;

  // random values still owed by the block, oldest first
  logic [31:0] expected_values[$];

  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;  // chance per cycle that the sender holds back
  int unsigned rx_idle_pct = 0;    // chance per cycle that the receiver holds back

  // long hold-off: armed by the stimulus, counted out by the result sink
  logic        hold_arm = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  permuted_congruential_generator_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One LCG step. The output is mixed from the state before the step:
  // xorshift-high, then rotate right by the top five bits.
  function automatic logic [31:0] pcg_advance();
    logic [pcg_pkg::StateW-1:0] old;
    logic [31:0]                mixed;
    logic [4:0]                 rot;
    logic [4:0]                 rot_l;
    old       = gen_state;
    gen_state = old * pcg_pkg::LcgMult + gen_inc;
    mixed     = 32'(((old >> 18) ^ old) >> 27);
    rot       = old[63:59];
    rot_l     = -rot;  // (32 - rot) mod 32, zero when rot is zero
    return (mixed >> rot) | (mixed << rot_l);
  endfunction

  // Expected random_value for one item, advancing the predictor state.
  function automatic logic [31:0] predict_draw(input logic op, input logic [31:0] bound);
    logic [31:0] threshold;
    logic [31:0] r;
    if (op == pcg_pkg::OP_RESEED) begin
      gen_state = '0;
      gen_inc   = {seed_seq, 1'b1};
      void'(pcg_advance());
      gen_state = gen_state + seed_st;
      void'(pcg_advance());
      return 32'd0;
    end
    if (bound == 32'd0) return pcg_advance();
    // unbiased: drop raw outputs below (2^32 - bound) mod bound
    threshold = (32'd0 - bound) % bound;
    do begin
      r = pcg_advance();
    end while (r < threshold);
    return r % bound;
  endfunction

  // Directed table: extremes of bound, both operations, the rejection corner
  // just above half range, and bound one, which always gives zero.
  function automatic draw_row_t directed_row(input int unsigned idx);
    draw_row_t row;
    case (idx)
      0:  row = '{pcg_pkg::OP_DRAW,   32'h0000_0000, 1'b0, 32'd0};  // raw output
      1:  row = '{pcg_pkg::OP_DRAW,   32'h0000_0001, 1'b1, 32'd0};  // always zero
      2:  row = '{pcg_pkg::OP_DRAW,   32'hFFFF_FFFF, 1'b0, 32'd0};
      3:  row = '{pcg_pkg::OP_DRAW,   32'h8000_0001, 1'b0, 32'd0};  // threshold near 2^31
      4:  row = '{pcg_pkg::OP_RESEED, 32'hFFFF_FFFF, 1'b1, 32'd0};
      5:  row = '{pcg_pkg::OP_DRAW,   32'h0000_0000, 1'b0, 32'd0};
      6:  row = '{pcg_pkg::OP_DRAW,   32'h0000_0002, 1'b0, 32'd0};
      7:  row = '{pcg_pkg::OP_DRAW,   32'h0000_0003, 1'b0, 32'd0};
      8:  row = '{pcg_pkg::OP_DRAW,   32'h8000_0000, 1'b0, 32'd0};
      9:  row = '{pcg_pkg::OP_DRAW,   32'h7FFF_FFFF, 1'b0, 32'd0};
      10: row = '{pcg_pkg::OP_RESEED, 32'h0000_0000, 1'b1, 32'd0};
      default: row = '{pcg_pkg::OP_DRAW, 32'h0000_0001, 1'b1, 32'd0};
    endcase
    return row;
  endfunction

  // Random item mix: small bounds most often, a share of heavy-rejection bounds,
  // raw draws, a few reseeds, and full 32-bit bounds so every bit toggles.
  function automatic void pick_item(output logic op, output logic [31:0] bound);
    int unsigned roll;
    roll  = $urandom_range(99);
    op    = pcg_pkg::OP_DRAW;
    bound = $urandom;
    if (roll < 6)       op    = pcg_pkg::OP_RESEED;
    else if (roll < 16) bound = 32'd0;
    else if (roll < 20) bound = 32'd1;
    else if (roll < 55) bound = $urandom_range(1000, 2);
    else if (roll < 70) bound = 32'h8000_0000 | $urandom_range(255);
  endfunction

  // Offer one item; valid is left high on return so a back-to-back item
  // reuses it. Anyone else who needs the bus quiet lowers it.
  task automatic send_item(input logic op, input logic [31:0] bound,
                           input logic known, input logic [31:0] known_value);
    logic [31:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= bound;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    predicted = predict_draw(op, bound);
    expected_values.push_back(known ? known_value : predicted);
  endtask

  // Stop offering and wait until every owed result has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_values.size() != 0);
  endtask

  // Both seed registers, back to back; only ever called with the block idle.
  task automatic write_seeds(input logic [63:0] st, input logic [63:0] sq);
    cfg_we    <= 1'b1;
    cfg_index <= pcg_pkg::REG_SEED_STATE;
    cfg_data  <= st;
    @(posedge clk);
    cfg_index <= pcg_pkg::REG_SEED_SEQUENCE;
    cfg_data  <= sq;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seed_st  = st;
    seed_seq = sq[pcg_pkg::SeqW-1:0];  // bit 63 is dropped by the register
  endtask

  // Result sink: checks each accepted item against the oldest expectation,
  // then picks the next ready, honoring the long hold-off when armed.
  initial begin : result_sink
    logic [31:0] want;
    logic        ready_next;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (expected_values.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result %h with nothing expected", $realtime, m_tdata);
        end else begin
          want = expected_values.pop_front();
          if (m_tdata !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: random_value expected %h got %h", $realtime, want, m_tdata);
          end
        end
      end
      if (rst) begin
        ready_next = 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (hold_arm && !hold_done) begin
        hold_done  = 1'b1;
        hold_left  = HoldCycles;
        ready_next = 1'b0;
      end else begin
        ready_next = ($urandom_range(99) >= rx_idle_pct);
      end
      m_tready <= ready_next;
    end
  end

  // Watchdog: any accepted item on either side restarts the count.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("permuted_congruential_generator_top verification failed");
    $finish;
  end

  initial begin : stimulus
    draw_row_t   row;
    logic        op;
    logic [31:0] bound;
    logic [63:0] st;
    logic [63:0] sq;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = pcg_pkg::OP_DRAW;
    cfg_we    = 1'b0;
    cfg_index = pcg_pkg::REG_SEED_STATE;
    cfg_data  = '0;

    // predictor after reset: published initializer, seeds zero
    gen_state = pcg_pkg::ResetState;
    gen_inc   = pcg_pkg::ResetInc;
    seed_st   = '0;
    seed_seq  = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: first pass with the reset seeds, second with all-ones seeds
    // (sequence bit 63 set to check the mask)
    send_idle_pct = 23;
    rx_idle_pct   = 70;
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        drain_results();
        write_seeds('1, '1);
      end
      for (int unsigned i = 0; i < RowCount; i++) begin
        row = directed_row(i);
        send_item(row.op, row.bound, row.known, row.known_value);
      end
    end

    // random phases: seeds change only with the block drained
    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain_results();
      case (phase)
        0:       begin st = '0; sq = '1; end
        1:       begin st = '1; sq = '0; end
        default: begin st = {$urandom, $urandom}; sq = {$urandom, $urandom}; end
      endcase
      write_seeds(st, sq);

      // receiver-heavy gaps, then sender-heavy, then flat out
      case (phase / 2)
        0:       begin send_idle_pct = 23; rx_idle_pct = 70; end
        1:       begin send_idle_pct = 70; rx_idle_pct = 23; end
        default: begin send_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      // long output stall with the sender flat out, so the input backs up
      if (phase == 4) hold_arm = 1'b1;

      for (int unsigned n = 0; n < PhaseItems; n++) begin
        pick_item(op, bound);
        send_item(op, bound, 1'b0, 32'd0);
        if ($urandom_range(199) == 0) drain_results();
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0)
      $display("permuted_congruential_generator_top verification clean");
    else
      $display("permuted_congruential_generator_top verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
src/pcg_pkg.sv
src/pcg_datapath.sv
src/pcg_controller.sv
src/permuted_congruential_generator_top.sv
src/pcg_checker.sv
tb/sv/permuted_congruential_generator_top_test.sv
